@@ rtl/tva_pkg.sv @@
// ----------------------------------------------------------------------------
// tva_pkg
// Shared types and constants of the three-valued logic ALU.
// ----------------------------------------------------------------------------
package tva_pkg;

  localparam int unsigned VEC_W    = 64;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned AMT_LIM  = 32;

  // Trit codes
  localparam logic [1:0] TRIT_ZERO = 2'd0;
  localparam logic [1:0] TRIT_ONE  = 2'd1;
  localparam logic [1:0] TRIT_X    = 2'd2;

  typedef enum logic [3:0] {
    K_NOT  = 4'd0,
    K_AND  = 4'd1,
    K_OR   = 4'd2,
    K_XOR  = 4'd3,
    K_MUX  = 4'd4,
    K_ADD  = 4'd5,
    K_EQ   = 4'd6,
    K_ULT  = 4'd7,
    K_SLT  = 4'd8,
    K_SHL  = 4'd9,
    K_USHR = 4'd10,
    K_SSHR = 4'd11,
    K_XSHR = 4'd12,
    K_MUL  = 4'd13,
    K_UDIV = 4'd14,
    K_UMOD = 4'd15
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic fin;
  } tva_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic iter_need;
  } tva_sts_t;

endpackage

@@ rtl/tva_ctrl.sv @@
// ----------------------------------------------------------------------------
// tva_ctrl
// Sequencer: load, prepare, iterate (mul/div), finish, present result.
// ----------------------------------------------------------------------------
module tva_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output tva_pkg::tva_cmd_t cmd,
  input  tva_pkg::tva_sts_t sts
);
  import tva_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_ITER = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cnt_last;

  assign cnt_last = (cnt_r == {CNT_W{1'b1}});

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        cnt_nxt   = '0;
        state_nxt = sts.iter_need ? S_ITER : S_FIN;
      end
      S_ITER: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Handshake and commands
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load  = (state_r == S_IDLE) && in_valid;
  assign cmd.prep  = (state_r == S_PREP);
  assign cmd.step  = (state_r == S_ITER);
  assign cmd.fin   = (state_r == S_FIN);

endmodule

@@ rtl/tva_dp.sv @@
// ----------------------------------------------------------------------------
// tva_dp
// Datapath: operand registers, shift-add multiplier, restoring divider
// and the result logic of all operations.
// ----------------------------------------------------------------------------
module tva_dp #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic        clk,
  input  tva_pkg::tva_cmd_t cmd,
  output tva_pkg::tva_sts_t sts,
  input  logic [3:0]  in_kind,
  input  logic [6:0]  in_op_width,
  input  logic [63:0] in_a_value,
  input  logic [63:0] in_a_unknown,
  input  logic [63:0] in_b_value,
  input  logic [63:0] in_b_unknown,
  input  logic [6:0]  in_amount_width,
  input  logic [1:0]  in_trit_in,
  input  logic [15:0] in_stride,
  output logic [63:0] out_y_value,
  output logic [63:0] out_y_unknown,
  output logic [1:0]  out_add_carry,
  output logic [1:0]  out_compare_out
);
  import tva_pkg::*;

  localparam logic [6:0] W_MAX = 7'(DATA_WIDTH);

  // Captured transaction
  kind_t       kind_r;
  logic [6:0]  w_r, aw_r;
  logic [63:0] a_v_r, a_u_r, b_v_r, b_u_r;
  logic [1:0]  trit_r;
  logic [15:0] stride_r;

  // Prepared shift info
  logic [47:0] sh_r;
  logic        big_r, amtx_r;

  // Iteration registers
  logic [63:0] wa_r, wb_r;
  logic [64:0] acc_r;

  // Result registers
  logic [63:0] yv_r, yu_r;
  logic [1:0]  carry_r, cmp_r;

  logic [6:0]  w_in, aw_in;
  logic [63:0] m, am, au, av, bu, bv, amt, amt_u;
  logic        anyx;

  // Width clamps
  always_comb begin
    priority if (in_op_width == 7'd0) w_in = 7'd1;
    else if (in_op_width > W_MAX)     w_in = W_MAX;
    else                              w_in = in_op_width;
    priority if (in_amount_width == 7'd0) aw_in = 7'd1;
    else if (in_amount_width > 7'd64)     aw_in = 7'd64;
    else                                  aw_in = in_amount_width;
  end

  // Masked operands
  assign m     = (w_r[6])  ? '1 : ((64'd1 << w_r[5:0])  - 64'd1);
  assign am    = (aw_r[6]) ? '1 : ((64'd1 << aw_r[5:0]) - 64'd1);
  assign au    = a_u_r & m;
  assign av    = a_v_r & m & ~au;
  assign bu    = b_u_r & m;
  assign bv    = b_v_r & m & ~bu;
  assign amt   = b_v_r & am;
  assign amt_u = b_u_r & am;
  assign anyx  = (au | bu) != 64'd0;

  // Mul and div iterate only when the operands are known
  always_comb begin
    sts.iter_need = 1'b0;
    if (!anyx) begin
      if (kind_r == K_MUL) sts.iter_need = 1'b1;
      else if ((kind_r == K_UDIV || kind_r == K_UMOD) && bv != 64'd0)
        sts.iter_need = 1'b1;
    end
  end

  // Capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= kind_t'(in_kind);
      w_r      <= w_in;
      aw_r     <= aw_in;
      a_v_r    <= in_a_value;
      a_u_r    <= in_a_unknown;
      b_v_r    <= in_b_value;
      b_u_r    <= in_b_unknown;
      trit_r   <= in_trit_in;
      stride_r <= in_stride;
    end
  end

  // Iteration step: shift-add multiply or restoring divide, one bit a cycle
  logic [64:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {acc_r[63:0], wa_r[63]};
  assign rem_ge = rem_sh >= {1'b0, bv};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      sh_r   <= amt[31:0] * stride_r;
      big_r  <= amt[63:AMT_LIM] != '0;
      amtx_r <= amt_u != 64'd0;
      wa_r   <= av;
      wb_r   <= bv;
      acc_r  <= '0;
    end else if (cmd.step) begin
      if (kind_r == K_MUL) begin
        if (wb_r[0]) acc_r <= {1'b0, acc_r[63:0] + wa_r};
        wa_r <= {wa_r[62:0], 1'b0};
        wb_r <= {1'b0, wb_r[63:1]};
      end else begin
        acc_r <= rem_ge ? (rem_sh - {1'b0, bv}) : rem_sh;
        wa_r  <= {wa_r[62:0], rem_ge};
      end
    end
  end

  // Result logic
  logic [5:0]  wm1;
  logic [64:0] sum;
  logic [63:0] xm, low, diff, flip, fill_v, fill_u, fm, zero_m, one_m;
  logic [5:0]  s;
  logic        top_u, top_v;
  logic [63:0] yv, yu;
  logic [1:0]  carry, cmp;

  assign wm1    = 6'(w_r - 7'd1);
  assign sum    = {1'b0, av} + {1'b0, bv} + {64'd0, (trit_r == TRIT_ONE)};
  assign xm     = au | bu;
  assign low    = ~xm & (xm - 64'd1);
  assign diff   = (av ^ bv) & ~au & ~bu;
  assign flip   = (kind_r == K_SLT) ? (64'd1 << wm1) : 64'd0;
  assign top_u  = au[wm1];
  assign top_v  = av[wm1];
  assign s      = sh_r[5:0];
  assign fm     = m & ~(m >> s);

  always_comb begin
    fill_v = '0;
    fill_u = '0;
    if (kind_r == K_SSHR) begin
      if (top_u)      fill_u = m;
      else if (top_v) fill_v = m;
    end else if (kind_r == K_XSHR) begin
      fill_u = m;
    end
  end

  always_comb begin
    yv     = '0;
    yu     = '0;
    carry  = TRIT_ZERO;
    cmp    = TRIT_ZERO;
    zero_m = '0;
    one_m  = '0;
    unique case (kind_r)
      K_NOT: begin
        yu = au;
        yv = ~av & ~au & m;
      end
      K_AND: begin
        zero_m = (~av & ~au) | (~bv & ~bu);
        one_m  = av & bv;
        yv = one_m;
        yu = m & ~zero_m & ~one_m;
      end
      K_OR: begin
        one_m  = av | bv;
        zero_m = ~av & ~au & ~bv & ~bu;
        yv = one_m;
        yu = m & ~zero_m & ~one_m;
      end
      K_XOR: begin
        yu = au | bu;
        yv = (av ^ bv) & ~yu;
      end
      K_MUX: begin
        if (trit_r == TRIT_ONE) begin
          yv = av; yu = au;
        end else if (trit_r == TRIT_ZERO) begin
          yv = bv; yu = bu;
        end else begin
          yu = (au | bu | (av ^ bv)) & m;
          yv = av & ~yu;
        end
      end
      K_ADD: begin
        if (trit_r[1]) begin
          yu = m;
          carry = TRIT_X;
        end else if (xm != 64'd0) begin
          // X from the lowest unknown bit upward
          yv = sum[63:0] & m & low;
          yu = m & ~low;
          carry = TRIT_X;
        end else begin
          yv = sum[63:0] & m;
          carry = {1'b0, sum[w_r]};
        end
      end
      K_EQ: begin
        if (diff != 64'd0) cmp = TRIT_ZERO;
        else               cmp = anyx ? TRIT_X : TRIT_ONE;
      end
      K_ULT, K_SLT: begin
        if (anyx) cmp = TRIT_X;
        else      cmp = ((av ^ flip) < (bv ^ flip)) ? TRIT_ONE : TRIT_ZERO;
      end
      K_SHL, K_USHR, K_SSHR, K_XSHR: begin
        if (amtx_r) begin
          yu = m;
        end else if (big_r && stride_r == 16'd0) begin
          yv = av; yu = au;
        end else if (big_r || sh_r >= {41'd0, w_r}) begin
          yv = fill_v; yu = fill_u;
        end else if (kind_r == K_SHL) begin
          yv = (av << s) & m;
          yu = (au << s) & m;
        end else begin
          yv = (av >> s) | (fill_v & fm);
          yu = (au >> s) | (fill_u & fm);
        end
      end
      K_MUL: begin
        if (anyx) yu = m;
        else      yv = acc_r[63:0] & m;
      end
      K_UDIV, K_UMOD: begin
        if (anyx || bv == 64'd0) yu = m;
        else yv = (kind_r == K_UDIV) ? wa_r : acc_r[63:0];
      end
      default: yu = m;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      yv_r    <= yv & ~yu & m;
      yu_r    <= yu & m;
      carry_r <= carry;
      cmp_r   <= cmp;
    end
  end

  assign out_y_value     = yv_r;
  assign out_y_unknown   = yu_r;
  assign out_add_carry   = carry_r;
  assign out_compare_out = cmp_r;

endmodule

@@ rtl/three_valued_alu_unit.sv @@
// ----------------------------------------------------------------------------
// three_valued_alu_unit
// ALU on three-valued (0, 1, X) vectors of up to 64 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transaction carries the operation, widths, both
//   operands as value/unknown word pairs, the trit input and the shift stride.
//   Result channel out_*: one transaction per input with the vector result,
//   the carry-out trit and the compare trit.
//   One transaction is in flight at a time; in_stall is high from acceptance
//   until the result has been taken.
//   From input acceptance the sequencer passes through prepare and finish for
//   bitwise, add, compare and shift operations; for mul, udiv and umod with known
//   operands (and a nonzero divisor) it iterates in between, through the 64 steps
//   of the shared shift-add / restoring divide unit (one bit a cycle). The
//   result is then shown until taken, and the sequencer returns to idle, where
//   the next input is taken.
//   When the receiver stalls, the result register holds and out_valid stays.
//   Synchronous reset returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
module three_valued_alu_unit #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_kind,
  input  logic [6:0]  in_op_width,
  input  logic [63:0] in_a_value,
  input  logic [63:0] in_a_unknown,
  input  logic [63:0] in_b_value,
  input  logic [63:0] in_b_unknown,
  input  logic [6:0]  in_amount_width,
  input  logic [1:0]  in_trit_in,
  input  logic [15:0] in_stride,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_y_value,
  output logic [63:0] out_y_unknown,
  output logic [1:0]  out_add_carry,
  output logic [1:0]  out_compare_out
);
  import tva_pkg::*;

  tva_cmd_t cmd;
  tva_sts_t sts;

  // Sequencer
  tva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath
  tva_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_op_width     (in_op_width),
    .in_a_value      (in_a_value),
    .in_a_unknown    (in_a_unknown),
    .in_b_value      (in_b_value),
    .in_b_unknown    (in_b_unknown),
    .in_amount_width (in_amount_width),
    .in_trit_in      (in_trit_in),
    .in_stride       (in_stride),
    .out_y_value     (out_y_value),
    .out_y_unknown   (out_y_unknown),
    .out_add_carry   (out_add_carry),
    .out_compare_out (out_compare_out)
  );

endmodule

@@ rtl/tva_chk.sv @@
// ----------------------------------------------------------------------------
// tva_chk
// Port-level checks of the three-valued ALU, bound to the top level.
// ----------------------------------------------------------------------------
module tva_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_add_carry,
  input logic [1:0] out_compare_out
);

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One transaction in flight: no new input while a result is shown
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // No result in the cycle right after an input transaction
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

  // Each result is delivered once
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

  // Trit outputs never use code three
  a_trit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_add_carry != 2'd3) && (out_compare_out != 2'd3))
    else $error("invalid trit code");

endmodule

bind three_valued_alu_unit tva_chk u_tva_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_add_carry   (out_add_carry),
  .out_compare_out (out_compare_out)
);

@@ tb/sv/tb_three_valued_alu_unit.sv @@
// ----------------------------------------------------------------------------
// tb_three_valued_alu_unit
// Self-checking bench: directed corner cases, then random three-valued
// operations, checked against a behavioral predictor under varying pressure.
// ----------------------------------------------------------------------------
module tb_three_valued_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tva_pkg::*;

  typedef struct {
    logic [3:0]  kind;
    logic [6:0]  op_width;
    logic [63:0] a_value;
    logic [63:0] a_unknown;
    logic [63:0] b_value;
    logic [63:0] b_unknown;
    logic [6:0]  amount_width;
    logic [1:0]  trit_in;
    logic [15:0] stride;
  } alu_op_t;

  typedef struct {
    logic [63:0] y_value;
    logic [63:0] y_unknown;
    logic [1:0]  add_carry;
    logic [1:0]  compare_out;
  } alu_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_kind;
  logic [6:0]  in_op_width;
  logic [63:0] in_a_value;
  logic [63:0] in_a_unknown;
  logic [63:0] in_b_value;
  logic [63:0] in_b_unknown;
  logic [6:0]  in_amount_width;
  logic [1:0]  in_trit_in;
  logic [15:0] in_stride;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_y_value;
  logic [63:0] out_y_unknown;
  logic [1:0]  out_add_carry;
  logic [1:0]  out_compare_out;
  logic        in_acc;

  alu_op_t  pending_ops[$];
  alu_res_t expected_res[$];
  int       errors;
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       hold_send;

  three_valued_alu_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_op_width(in_op_width),
    .in_a_value(in_a_value), .in_a_unknown(in_a_unknown),
    .in_b_value(in_b_value), .in_b_unknown(in_b_unknown),
    .in_amount_width(in_amount_width), .in_trit_in(in_trit_in),
    .in_stride(in_stride),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_y_value(out_y_value), .out_y_unknown(out_y_unknown),
    .out_add_carry(out_add_carry), .out_compare_out(out_compare_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] lsb_mask(int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  // Behavioral prediction of one ALU transaction
  function automatic alu_res_t predict_alu(alu_op_t op);
    alu_res_t r;
    int unsigned w, aw, p;
    logic [63:0] m, au, av, bu, bv, zero, one, low, am, amt, amt_u, fm;
    logic [63:0] fill_v, fill_u, yv, yu, flip;
    logic [64:0] sum;
    logic [1:0]  trit, sign, carry, cmp;
    logic [127:0] s;
    logic big, anyx, c;
    w = (op.op_width == 0) ? 1 : (op.op_width > 64 ? 64 : op.op_width);
    m = lsb_mask(w);
    au = op.a_unknown & m;
    av = op.a_value & m & ~au;
    bu = op.b_unknown & m;
    bv = op.b_value & m & ~bu;
    trit = (op.trit_in == 2'd3) ? TRIT_X : op.trit_in;
    anyx = (au | bu) != 0;
    yv = '0; yu = '0; carry = TRIT_ZERO; cmp = TRIT_ZERO;
    case (kind_t'(op.kind))
      K_NOT: begin
        yu = au; yv = ~av & ~au & m;
      end
      K_AND: begin
        zero = (~av & ~au) | (~bv & ~bu);
        one = av & bv;
        yv = one; yu = m & ~zero & ~one;
      end
      K_OR: begin
        one = av | bv;
        zero = ~av & ~au & ~bv & ~bu;
        yv = one; yu = m & ~zero & ~one;
      end
      K_XOR: begin
        yu = au | bu; yv = (av ^ bv) & ~yu;
      end
      K_MUX: begin
        if (trit == TRIT_ONE) begin
          yv = av; yu = au;
        end else if (trit == TRIT_ZERO) begin
          yv = bv; yu = bu;
        end else begin
          yu = (au | bu | (av ^ bv)) & m;
          yv = av & ~yu;
        end
      end
      K_ADD: begin
        c = (trit == TRIT_ONE);
        sum = {1'b0, av} + {1'b0, bv} + c;
        p = w;
        if (trit == TRIT_X) p = 0;
        else begin
          for (int i = w - 1; i >= 0; i--)
            if ((au[i] | bu[i]) == 1'b1) p = i;
        end
        if (p < w) begin
          low = lsb_mask(p);
          yv = sum[63:0] & m & low;
          yu = m & ~low;
          carry = TRIT_X;
        end else begin
          yv = sum[63:0] & m;
          carry = sum[w] ? TRIT_ONE : TRIT_ZERO;
        end
      end
      K_EQ: begin
        if (((av ^ bv) & ~au & ~bu) != 0) cmp = TRIT_ZERO;
        else cmp = anyx ? TRIT_X : TRIT_ONE;
      end
      K_ULT, K_SLT: begin
        if (anyx) cmp = TRIT_X;
        else begin
          flip = (op.kind == K_SLT) ? (64'd1 << (w - 1)) : 64'd0;
          cmp = ((av ^ flip) < (bv ^ flip)) ? TRIT_ONE : TRIT_ZERO;
        end
      end
      K_SHL, K_USHR, K_SSHR, K_XSHR: begin
        aw = (op.amount_width == 0) ? 1 : (op.amount_width > 64 ? 64 : op.amount_width);
        am = lsb_mask(aw);
        amt_u = op.b_unknown & am;
        amt = op.b_value & am;
        sign = au[w-1] ? TRIT_X : {1'b0, av[w-1]};
        fill_v = '0; fill_u = '0;
        if (op.kind == K_SSHR) begin
          if (sign == TRIT_X) fill_u = m;
          else if (sign == TRIT_ONE) fill_v = m;
        end else if (op.kind == K_XSHR) fill_u = m;
        big = (amt >> AMT_LIM) != 0;
        if (amt_u != 0) yu = m;
        else if (big && op.stride == 0) begin
          yv = av; yu = au;
        end else begin
          s = big ? 128'(w) : 128'(amt) * 128'(op.stride);
          if (s >= w) begin
            yv = fill_v; yu = fill_u;
          end else if (op.kind == K_SHL) begin
            yv = (av << s[6:0]) & m; yu = (au << s[6:0]) & m;
          end else begin
            fm = m & ~(m >> s[6:0]);
            yv = (av >> s[6:0]) | (fill_v & fm);
            yu = (au >> s[6:0]) | (fill_u & fm);
          end
        end
      end
      K_MUL: begin
        if (anyx) yu = m; else yv = (av * bv) & m;
      end
      default: begin
        if (anyx || bv == 0) yu = m;
        else yv = (op.kind == K_UDIV) ? (av / bv) : (av % bv);
      end
    endcase
    r.y_value = yv & ~yu & m;
    r.y_unknown = yu & m;
    r.add_carry = carry;
    r.compare_out = cmp;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random operand: mix of plain, sparse-X and extreme words
  function automatic logic [63:0] pick_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'(1) << $urandom_range(63);
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] pick_x_mask();
    case ($urandom_range(7))
      0, 1, 2: return '0;
      3: return 64'(1) << $urandom_range(63);
      4: return '1;
      default: return rand64() & rand64();
    endcase
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    op.kind = 4'($urandom_range(15));
    case ($urandom_range(3))
      0: op.op_width = 7'($urandom_range(127));
      1: op.op_width = 7'(64);
      default: op.op_width = 7'($urandom_range(1, 64));
    endcase
    op.a_value = pick_word();
    op.a_unknown = pick_x_mask();
    op.b_value = pick_word();
    op.b_unknown = pick_x_mask();
    op.amount_width = 7'($urandom_range(127));
    op.trit_in = 2'($urandom_range(3));
    op.stride = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    // Shifts: mostly small known amounts so that real shifting happens
    if (op.kind >= K_SHL && op.kind <= K_XSHR && $urandom_range(3) != 0) begin
      op.b_value = ($urandom_range(4) == 0) ? rand64() : 64'($urandom_range(70));
      op.b_unknown = ($urandom_range(5) == 0) ? pick_x_mask() : '0;
    end
    return op;
  endfunction

  function automatic alu_op_t make_op(logic [3:0] k, logic [6:0] w, logic [63:0] av,
                                      logic [63:0] au, logic [63:0] bv, logic [63:0] bu,
                                      logic [6:0] aw, logic [1:0] t, logic [15:0] st);
    alu_op_t op;
    op.kind = k; op.op_width = w; op.a_value = av; op.a_unknown = au;
    op.b_value = bv; op.b_unknown = bu; op.amount_width = aw;
    op.trit_in = t; op.stride = st;
    return op;
  endfunction

  // Input acceptance seen at the rising edge
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
  end

  // Driver: presents queued transactions, updates at falling edges
  always @(negedge clk) begin
    alu_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_acc) begin
      // hold payload
    end else if (pending_ops.size() > 0 && !hold_send &&
                 $urandom_range(99) >= send_idle_pct) begin
      op = pending_ops.pop_front();
      in_valid <= 1'b1;
      in_kind <= op.kind;
      in_op_width <= op.op_width;
      in_a_value <= op.a_value;
      in_a_unknown <= op.a_unknown;
      in_b_value <= op.b_value;
      in_b_unknown <= op.b_unknown;
      in_amount_width <= op.amount_width;
      in_trit_in <= op.trit_in;
      in_stride <= op.stride;
      expected_res.insert(expected_res.size(), predict_alu(op));
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: compares each accepted result with the oldest expectation
  always @(posedge clk) begin
    alu_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_res.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (out_y_value !== e.y_value) begin
          $error("y_value expected %h actual %h", e.y_value, out_y_value);
          errors++;
        end
        if (out_y_unknown !== e.y_unknown) begin
          $error("y_unknown expected %h actual %h", e.y_unknown, out_y_unknown);
          errors++;
        end
        if (out_add_carry !== e.add_carry) begin
          $error("add_carry expected %0d actual %0d", e.add_carry, out_add_carry);
          errors++;
        end
        if (out_compare_out !== e.compare_out) begin
          $error("compare_out expected %0d actual %0d", e.compare_out, out_compare_out);
          errors++;
        end
      end
    end
  end

  task automatic drain_phase();
    while (pending_ops.size() > 0 || in_valid || expected_res.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_ops.insert(pending_ops.size(), random_op());
    drain_phase();
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_send = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_kind = '0; in_op_width = 7'd1;
    in_a_value = '0; in_a_unknown = '0; in_b_value = '0; in_b_unknown = '0;
    in_amount_width = 7'd1; in_trit_in = '0; in_stride = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed corners: extremes, each op, X handling, special cases
    for (int k = 0; k < 16; k++)
      pending_ops.insert(pending_ops.size(),
                         make_op(4'(k), 7'd64, '1, '0, '1, '0, 7'd64, TRIT_ONE, '1));
    pending_ops.insert(pending_ops.size(),
                       make_op(K_ADD, 7'd64, '1, 64'h100, 64'd1, '0, 7'd1, TRIT_ZERO, 0));
    pending_ops.insert(pending_ops.size(),
                       make_op(K_ADD, 7'd0, '1, '0, '1, '0, 7'd1, 2'd3, 0));
    pending_ops.insert(pending_ops.size(),
                       make_op(K_MUX, 7'd100, 64'hF0F0, 64'h0F00, 64'hFF00, '0,
                               7'd0, TRIT_X, 0));
    pending_ops.insert(pending_ops.size(),
                       make_op(K_EQ, 7'd8, 64'h01, 64'h80, 64'h00, '0, 7'd1, 0, 0));
    pending_ops.insert(pending_ops.size(),
                       make_op(K_UDIV, 7'd16, 64'h1234, '0, '0, '0, 7'd1, 0, 0));
    pending_ops.insert(pending_ops.size(),
                       make_op(K_SSHR, 7'd32, 64'h8000_0000, '0, 64'h1_0000_0000, '0,
                               7'd64, 0, 16'd0));
    pending_ops.insert(pending_ops.size(),
                       make_op(K_SSHR, 7'd32, 64'h8000_0000, '0, 64'h1_0000_0000, '0,
                               7'd64, 0, 16'd1));
    pending_ops.insert(pending_ops.size(),
                       make_op(K_XSHR, 7'd12, 64'hABC, 64'h800, 64'd3, '0, 7'd4, 0, 16'd2));
    pending_ops.insert(pending_ops.size(),
                       make_op(K_SHL, 7'd64, '1, '0, 64'd5, 64'd1, 7'd3, 0, 16'd1));
    drain_phase();

    // Random phases under different pressure
    run_random(300, 0, 0);
    run_random(250, 78, 0);
    // sender holds off until the block is fully drained
    hold_send = 1'b1;
    for (int i = 0; i < 20; i++) pending_ops.insert(pending_ops.size(), random_op());
    drain_phase_quiet();
    hold_send = 1'b0;
    run_random(230, 0, 78);
    run_random(250, 26, 26);
    run_random(200, 0, 0);

    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("tb_three_valued_alu_unit passed");
    end else begin
      $display("tb_three_valued_alu_unit failed");
    end
    $finish;
  end

  task automatic drain_phase_quiet();
    while (in_valid || expected_res.size() > 0) @(posedge clk);
  endtask

  // Run limit
  initial begin
    #3_000_000;
    $display("tb_three_valued_alu_unit failed");
    $finish;
  end

endmodule
